// ===== design/kslp_pkg.sv =====
// Shared constants, types and helpers for the key short/long press detector.
`timescale 1ns / 1ps
`default_nettype none
package kslp_pkg;

    // Number of keys scanned per tick.
    localparam int NUM_KEYS = 4;
    // Width of the per-key pressed and released tick counters.
    localparam int COUNT_WIDTH = 8;
    // Width of the configuration thresholds.
    localparam int CFG_WIDTH = 8;
    // Common width used when a counter is compared with a threshold.
    localparam int CMP_WIDTH = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;
    // Saturation value of the tick counters.
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    // Register reset values.
    localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET = CFG_WIDTH'(2);
    localparam logic [CFG_WIDTH-1:0] LONG_RESET     = CFG_WIDTH'(200);

    // Register indexes on the configuration port.
    localparam logic REG_DEBOUNCE = 1'b0;
    localparam logic REG_LONG     = 1'b1;

    // Per-key phase, one-hot.
    typedef enum logic [2:0] {
        PH_IDLE     = 3'b001,
        PH_RELEASED = 3'b010,
        PH_CLASSIFY = 3'b100
    } t_phase;

    // Events that one lane reports for the current tick.
    typedef struct packed {
        logic short_evt;
        logic long_evt;
    } t_lane_evt;

    // Result of one tick after merging all lanes.
    typedef struct packed {
        logic [NUM_KEYS-1:0] short_mask;
        logic [NUM_KEYS-1:0] long_mask;
    } t_result;

    // Saturating increment of a tick counter.
    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
        sat_inc = (v == COUNT_MAX) ? COUNT_MAX : v + COUNT_WIDTH'(1);
    endfunction

    // Counter at or above threshold.
    function automatic logic reached(input logic [COUNT_WIDTH-1:0] cnt,
                                     input logic [CFG_WIDTH-1:0] thr);
        reached = CMP_WIDTH'(cnt) >= CMP_WIDTH'(thr);
    endfunction

endpackage
`default_nettype wire

// ===== design/kslp_lane.sv =====
// One key's press machine: debounce counters, phase register and event decode.
`timescale 1ns / 1ps
`default_nettype none
module kslp_lane (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_step,
    input  wire logic                               i_level,
    input  wire logic [kslp_pkg::CFG_WIDTH-1:0]     i_debounce_ticks,
    input  wire logic [kslp_pkg::CFG_WIDTH-1:0]     i_long_press_ticks,
    output kslp_pkg::t_lane_evt                     o_evt
);

    kslp_pkg::t_phase                   r_phase, n_phase;
    logic [kslp_pkg::COUNT_WIDTH-1:0]   r_press, n_press;
    logic [kslp_pkg::COUNT_WIDTH-1:0]   r_release, n_release;
    logic                               pressed;

    // The pin is active low.
    assign pressed = ~i_level;

    // Next state of the key machine for the tick being taken.
    always_comb begin
        n_phase     = r_phase;
        n_press     = r_press;
        n_release   = r_release;
        o_evt       = '0;
        case (r_phase)
            kslp_pkg::PH_IDLE: begin
                if (pressed) begin
                    n_press = kslp_pkg::sat_inc(r_press);
                end else if (kslp_pkg::reached(r_press, i_debounce_ticks)) begin
                    n_phase = kslp_pkg::PH_RELEASED;
                end else begin
                    n_press = '0;
                end
            end
            kslp_pkg::PH_RELEASED: begin
                // The threshold test uses the count after this tick's update.
                if (!pressed) begin
                    n_release = kslp_pkg::sat_inc(r_release);
                end
                if (kslp_pkg::reached(n_release, i_debounce_ticks)) begin
                    n_phase = kslp_pkg::PH_CLASSIFY;
                end
            end
            kslp_pkg::PH_CLASSIFY: begin
                if (kslp_pkg::reached(r_press, i_long_press_ticks)) begin
                    o_evt.long_evt = 1'b1;
                end else begin
                    o_evt.short_evt = 1'b1;
                end
                n_press   = '0;
                n_release = '0;
                n_phase   = kslp_pkg::PH_IDLE;
            end
            default: begin
                n_phase = kslp_pkg::PH_IDLE;
            end
        endcase
    end

    // State registers advance only on an accepted tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= kslp_pkg::PH_IDLE;
            r_press   <= '0;
            r_release <= '0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_press   <= n_press;
            r_release <= n_release;
        end
    end

endmodule
`default_nettype wire

// ===== design/kslp_merge.sv =====
// Merges the lane events into one result and holds it in an output register with a skid slot.
`timescale 1ns / 1ps
`default_nettype none
module kslp_merge (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_step,
    input  wire kslp_pkg::t_lane_evt [kslp_pkg::NUM_KEYS-1:0] i_evts,
    input  wire logic                                   i_out_stall,
    output logic                                        o_full,
    output logic                                        o_out_valid,
    output kslp_pkg::t_result                           o_result
);

    kslp_pkg::t_result  n_result;
    kslp_pkg::t_result  r_out, r_skid;
    logic               r_out_vld, r_skid_vld;
    logic               out_free;

    // Gather each lane's event bit into the masks.
    always_comb begin
        n_result = '0;
        for (int k = 0; k < kslp_pkg::NUM_KEYS; k++) begin
            n_result.short_mask[k] = i_evts[k].short_evt;
            n_result.long_mask[k]  = i_evts[k].long_evt;
        end
    end

    // The output slot can take a new result when empty or being drained.
    assign out_free = !r_out_vld || !i_out_stall;

    // Control of the output register and the skid slot.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (out_free) begin
            if (r_skid_vld) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld  <= i_step;
            end
        end else if (i_step) begin
            r_skid_vld <= 1'b1;
        end
    end

    // Payload of the output register and the skid slot.
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_vld ? r_skid : n_result;
        end else if (i_step) begin
            r_skid <= n_result;
        end
    end

    assign o_full      = r_skid_vld;
    assign o_out_valid = r_out_vld;
    assign o_result    = r_out;

endmodule
`default_nettype wire

// ===== design/key_short_long_press_detector_unit.sv =====
// Top level of the key short/long press detector: register port, key lanes and result merge.
// Each request is one scan tick carrying the active-low levels of four keys; every key has its
// own lane with a debounce machine, and one result with a short-event and a long-event mask
// comes back for every request. A request is taken in every cycle while the input does not stall, and
// its result is registered in the output register; a skid slot behind that register lets
// one more request in while a result waits, so the input stalls only when both are full. The
// debounce and long-press thresholds sit at byte addresses 0 and 4 of the register port and are
// meant to be written while no request is in flight.
`timescale 1ns / 1ps
`default_nettype none
module key_short_long_press_detector_unit (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // Register port
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [2:0]                         paddr,
    input  wire logic [31:0]                        pwdata,
    output logic [31:0]                             prdata,
    output logic                                    pready,
    // Scan tick requests
    input  wire logic                               i_valid,
    output logic                                    o_stall,
    input  wire logic [kslp_pkg::NUM_KEYS-1:0]      i_key_levels,
    // Event results
    output logic                                    o_valid,
    input  wire logic                               i_stall,
    output logic [kslp_pkg::NUM_KEYS-1:0]           o_short_events,
    output logic [kslp_pkg::NUM_KEYS-1:0]           o_long_events
);

    logic [kslp_pkg::CFG_WIDTH-1:0]                 r_debounce_ticks;
    logic [kslp_pkg::CFG_WIDTH-1:0]                 r_long_press_ticks;
    logic                                           cfg_wr;
    logic                                           step;
    logic                                           full;
    kslp_pkg::t_lane_evt [kslp_pkg::NUM_KEYS-1:0]   evts;
    kslp_pkg::t_result                              result;

    // Register writes complete in the access phase.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ticks   <= kslp_pkg::DEBOUNCE_RESET;
            r_long_press_ticks <= kslp_pkg::LONG_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                kslp_pkg::REG_DEBOUNCE: r_debounce_ticks   <= pwdata[kslp_pkg::CFG_WIDTH-1:0];
                kslp_pkg::REG_LONG:     r_long_press_ticks <= pwdata[kslp_pkg::CFG_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // Register read back.
    always_comb begin
        case (paddr[2])
            kslp_pkg::REG_DEBOUNCE: prdata = 32'(r_debounce_ticks);
            kslp_pkg::REG_LONG:     prdata = 32'(r_long_press_ticks);
            default:                prdata = '0;
        endcase
    end

    // A request is taken whenever the skid slot is free.
    assign o_stall = full;
    assign step    = i_valid && !full;

    // One lane per key.
    for (genvar k = 0; k < kslp_pkg::NUM_KEYS; k++) begin : g_lane
        kslp_lane u_lane (
            .i_clk              (i_clk),
            .i_rst_n            (i_rst_n),
            .i_step             (step),
            .i_level            (i_key_levels[k]),
            .i_debounce_ticks   (r_debounce_ticks),
            .i_long_press_ticks (r_long_press_ticks),
            .o_evt              (evts[k])
        );
    end

    // Merge lanes and buffer the result.
    kslp_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_evts      (evts),
        .i_out_stall (i_stall),
        .o_full      (full),
        .o_out_valid (o_valid),
        .o_result    (result)
    );

    assign o_short_events = result.short_mask;
    assign o_long_events  = result.long_mask;

endmodule
`default_nettype wire

// ===== design/kslp_checker.sv =====
// Port-level checks for the key short/long press detector, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module kslp_port_props (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_valid,
    input wire logic                            o_stall,
    input wire logic                            o_valid,
    input wire logic                            i_stall,
    input wire logic [kslp_pkg::NUM_KEYS-1:0]   o_short_events,
    input wire logic [kslp_pkg::NUM_KEYS-1:0]   o_long_events
);

    // A key never reports a short and a long press in the same result.
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_short_events & o_long_events) == '0))
        else $error("short and long event on the same key");

    // The input stalls only while a result is waiting at the output.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with an empty output");

    // A stalled result stays in place.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_short_events)
                                  && $stable(o_long_events)))
        else $error("stalled result changed");

    // An accepted request always leaves a result at the output on the next cycle.
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_valid)
        else $error("accepted request left no result");

    // Reset empties the output and frees the input.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !o_stall))
        else $error("output not empty after reset");

endmodule

bind key_short_long_press_detector_unit kslp_port_props u_kslp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_short_events (o_short_events),
    .o_long_events  (o_long_events)
);
`default_nettype wire
